// File: hdl/rlnh_pkg.sv
// ---------------------------------------------------------------------------
// Ring lookup router package
// Shared codes, types and default sizes for the ring lookup next-hop router.
// ---------------------------------------------------------------------------
package rlnh_pkg;

  localparam int FINGER_SLOTS_DEF = 16;
  localparam int ID_BITS_DEF      = 8;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_SUBMIT = 2'd2;

  localparam logic [1:0] ACT_FWD     = 2'd0;
  localparam logic [1:0] ACT_DELIVER = 2'd1;
  localparam logic [1:0] ACT_DROP    = 2'd2;
  localparam logic [1:0] ACT_WRITTEN = 2'd3;

  localparam logic REG_SELF_ID  = 1'b0;
  localparam logic REG_STOP_THR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

endpackage

// File: hdl/ring_lookup_next_hop_router_top.sv
// ---------------------------------------------------------------------------
// Ring lookup next-hop router
// One node's routing step on an identifier ring with a finger table.
// ---------------------------------------------------------------------------
// An item is taken at a clock edge with start high and busy low. Op 0 writes
// a finger slot, op 1 is an arriving lookup, op 2 a local submit; op 3 is
// ignored and gives no result. Each result shows for one cycle with done high;
// the receiver always takes it.
// Slot writes, and lookups and submits for this node, answer in the cycle after
// the beat, and the block takes the next item in that same cycle. Any other
// lookup or submit scans the finger memory, one slot read per cycle, and holds
// busy high until the scan ends; done rises as the block returns to idle. The
// memory's one read port sets that rate. The running totals sit on their ports
// at all times and are valid with done. Configuration writes on cfg_we take
// effect at once; the user must make them while the block is idle, which the
// block does not enforce. Reset clears the registers, the totals and all valid
// bits; finger identifiers need no clearing since unused slots are never valid.
// ---------------------------------------------------------------------------
module ring_lookup_next_hop_router_top #(
  parameter int FINGER_SLOTS = rlnh_pkg::FINGER_SLOTS_DEF,
  parameter int ID_BITS      = rlnh_pkg::ID_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_idx,
  input  logic [31:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [3:0]         slot,
  input  logic [7:0]         node_id,
  input  logic               slot_valid,
  input  logic [7:0]         target_id,
  input  logic [7:0]         hops_in,
  input  logic [31:0]        round_submitted,
  input  logic [31:0]        current_round,
  output logic               done,
  output logic [1:0]         action,
  output logic [7:0]         next_hop,
  output logic [7:0]         hops_out,
  output logic               stop_now,
  output logic [31:0]        satisfied_count,
  output logic [31:0]        total_hops,
  output logic [7:0]         max_hops,
  output logic signed [47:0] total_latency
);

  localparam int SW = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;
  localparam int CW = $clog2(FINGER_SLOTS + 1);

  rlnh_pkg::state_t state;

  logic [7:0]        self_id;
  logic [31:0]       stop_threshold;
  logic [FINGER_SLOTS-1:0] finger_valid;
  logic [31:0]       sat;
  logic [31:0]       hop_sum;
  logic [7:0]        peak;
  logic [47:0]       lat;
  logic              stop_raised;

  logic [CW-1:0]     cnt;
  logic              vld_q;
  logic [ID_BITS-1:0] tdist_q;
  logic [7:0]        hops_q;
  logic              fin_in;
  logic [ID_BITS-1:0] din;
  logic [ID_BITS-1:0] id_in;
  logic              fin_sc;
  logic [ID_BITS-1:0] dsc;
  logic [ID_BITS-1:0] id_sc;

  logic [39:0]       node_ext;
  logic [39:0]       target_ext;
  logic [39:0]       self_ext;
  logic [ID_BITS-1:0] node_idw;
  logic [ID_BITS-1:0] target_idw;
  logic [ID_BITS-1:0] me;
  logic [11:0]       slot_ext;
  logic              slot_in_range;
  logic [SW-1:0]     waddr;
  logic [SW-1:0]     raddr;
  logic              ram_we;
  logic [ID_BITS-1:0] rdata;

  logic              accept;
  logic              is_self;
  logic [31:0]       sat_inc;
  logic [32:0]       hs_sum;
  logic [31:0]       hs_next;
  logic [32:0]       lat_diff;
  logic [47:0]       lat_next;
  logic              stop_hit;

  logic              scan_eval;
  logic              scan_last;
  logic [ID_BITS-1:0] d;
  logic              cand;
  logic              in_hit;
  logic              sc_hit;
  logic              fin_in_next;
  logic [ID_BITS-1:0] din_next;
  logic [ID_BITS-1:0] id_in_next;
  logic              fin_sc_next;
  logic [ID_BITS-1:0] dsc_next;
  logic [ID_BITS-1:0] id_sc_next;
  logic [39:0]       hop_ext;
  logic [7:0]        hops_inc;

  assign busy   = (state != rlnh_pkg::ST_IDLE);
  assign accept = start && (state == rlnh_pkg::ST_IDLE);

  assign node_ext   = 40'(node_id);
  assign target_ext = 40'(target_id);
  assign self_ext   = 40'(self_id);
  assign node_idw   = node_ext[ID_BITS-1:0];
  assign target_idw = target_ext[ID_BITS-1:0];
  assign me         = self_ext[ID_BITS-1:0];
  assign is_self    = (target_idw == me);

  assign slot_ext      = 12'(slot);
  assign slot_in_range = (slot_ext < 12'(FINGER_SLOTS));
  assign waddr         = slot_ext[SW-1:0];
  assign raddr         = cnt[SW-1:0];
  assign ram_we        = accept && (op == rlnh_pkg::OP_WRITE) && slot_in_range;

  rlnh_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (FINGER_SLOTS),
    .AW    (SW)
  ) u_finger_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (node_idw),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sat_inc  = (sat == 32'hFFFF_FFFF) ? sat : sat + 32'd1;
    hs_sum   = {1'b0, hop_sum} + 33'(hops_in);
    hs_next  = hs_sum[32] ? 32'hFFFF_FFFF : hs_sum[31:0];
    lat_diff = {1'b0, current_round} - {1'b0, round_submitted};
    lat_next = lat + {{15{lat_diff[32]}}, lat_diff};
    stop_hit = !stop_raised && (stop_threshold != 32'd0) && (sat_inc >= stop_threshold);
  end

  always_comb begin
    scan_eval   = (state == rlnh_pkg::ST_SCAN) && (cnt != '0);
    scan_last   = (state == rlnh_pkg::ST_SCAN) && (cnt == CW'(FINGER_SLOTS));
    d           = rdata - me;
    cand        = scan_eval && vld_q && (d != '0);
    in_hit      = cand && (d <= tdist_q) && (!fin_in || (d > din));
    sc_hit      = cand && (!fin_sc || (d < dsc));
    fin_in_next = fin_in || in_hit;
    din_next    = in_hit ? d : din;
    id_in_next  = in_hit ? rdata : id_in;
    fin_sc_next = fin_sc || sc_hit;
    dsc_next    = sc_hit ? d : dsc;
    id_sc_next  = sc_hit ? rdata : id_sc;
    hop_ext     = 40'(fin_in_next ? id_in_next : id_sc_next);
    hops_inc    = (hops_q == 8'hFF) ? hops_q : hops_q + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= rlnh_pkg::ST_IDLE;
      cnt            <= '0;
      done           <= 1'b0;
      stop_now       <= 1'b0;
      self_id        <= '0;
      stop_threshold <= '0;
      finger_valid   <= '0;
      sat            <= '0;
      hop_sum        <= '0;
      peak           <= '0;
      lat            <= '0;
      stop_raised    <= 1'b0;
      fin_in         <= 1'b0;
      fin_sc         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          rlnh_pkg::REG_SELF_ID:  self_id        <= cfg_data[7:0];
          rlnh_pkg::REG_STOP_THR: stop_threshold <= cfg_data;
          default: ;
        endcase
      end
      done     <= 1'b0;
      stop_now <= 1'b0;
      case (state)
        rlnh_pkg::ST_IDLE: begin
          if (start) begin
            case (op)
              rlnh_pkg::OP_WRITE: begin
                if (slot_in_range) begin
                  finger_valid[waddr] <= slot_valid;
                end
                done     <= 1'b1;
                action   <= rlnh_pkg::ACT_WRITTEN;
                next_hop <= '0;
                hops_out <= '0;
              end
              rlnh_pkg::OP_LOOKUP, rlnh_pkg::OP_SUBMIT: begin
                if (is_self) begin
                  sat      <= sat_inc;
                  done     <= 1'b1;
                  action   <= rlnh_pkg::ACT_DELIVER;
                  next_hop <= '0;
                  if (op == rlnh_pkg::OP_LOOKUP) begin
                    hops_out <= hops_in;
                    hop_sum  <= hs_next;
                    lat      <= lat_next;
                    if (hops_in > peak) begin
                      peak <= hops_in;
                    end
                    if (stop_hit) begin
                      stop_raised <= 1'b1;
                      stop_now    <= 1'b1;
                    end
                  end else begin
                    hops_out <= '0;
                  end
                end else begin
                  state   <= rlnh_pkg::ST_SCAN;
                  cnt     <= '0;
                  fin_in  <= 1'b0;
                  fin_sc  <= 1'b0;
                  tdist_q <= target_idw - me;
                  hops_q  <= (op == rlnh_pkg::OP_LOOKUP) ? hops_in : 8'd0;
                end
              end
              default: ;
            endcase
          end
        end
        rlnh_pkg::ST_SCAN: begin
          cnt    <= cnt + CW'(1);
          vld_q  <= (cnt < CW'(FINGER_SLOTS)) && finger_valid[raddr];
          fin_in <= fin_in_next;
          din    <= din_next;
          id_in  <= id_in_next;
          fin_sc <= fin_sc_next;
          dsc    <= dsc_next;
          id_sc  <= id_sc_next;
          if (scan_last) begin
            state <= rlnh_pkg::ST_IDLE;
            done  <= 1'b1;
            if (fin_in_next || fin_sc_next) begin
              action   <= rlnh_pkg::ACT_FWD;
              next_hop <= hop_ext[7:0];
              hops_out <= hops_inc;
            end else begin
              action   <= rlnh_pkg::ACT_DROP;
              next_hop <= '0;
              hops_out <= hops_q;
            end
          end
        end
        default: state <= rlnh_pkg::ST_IDLE;
      endcase
    end
  end

  assign satisfied_count = sat;
  assign total_hops      = hop_sum;
  assign max_hops        = peak;
  assign total_latency   = $signed(lat);

endmodule

// File: hdl/rlnh_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ---------------------------------------------------------------------------
module rlnh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/rlnh_checker.sv
// ---------------------------------------------------------------------------
// Ring lookup router checker
// Port-level checks on the router's results, bound to the top level.
// ---------------------------------------------------------------------------
module rlnh_checker (
  input logic       clk,
  input logic       rst,
  input logic       done,
  input logic [1:0] action,
  input logic [7:0] next_hop,
  input logic [7:0] hops_out,
  input logic       stop_now,
  input logic [7:0] max_hops
);

  a_stop_on_delivery: assert property (@(posedge clk) disable iff (rst)
    stop_now |-> done && (action == rlnh_pkg::ACT_DELIVER))
    else $error("stop raised on a beat that is not a delivery");

  a_fwd_hops: assert property (@(posedge clk) disable iff (rst)
    done && (action == rlnh_pkg::ACT_FWD) |-> (hops_out != 8'd0))
    else $error("forwarded lookup carries a zero hop count");

  a_no_hop_when_idle: assert property (@(posedge clk) disable iff (rst)
    done && ((action == rlnh_pkg::ACT_WRITTEN) || (action == rlnh_pkg::ACT_DROP))
      |-> (next_hop == 8'd0))
    else $error("next hop set on a result that is not forwarded");

  a_peak_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (max_hops >= $past(max_hops)))
    else $error("maximum hop count decreased");

endmodule

bind ring_lookup_next_hop_router_top rlnh_checker u_rlnh_checker (.*);

// File: verif/tb_top.sv
// ---------------------------------------------------------------------------
// Ring lookup router testbench
// Drives finger writes, lookups and local submits into the router and checks
// every result against a cycle-free predictor of the routing step and the
// running delivery totals. A short scripted table comes first, then random
// traffic over several settings of this node's id and the stop threshold.
// ---------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SLOTS = rlnh_pkg::FINGER_SLOTS_DEF;
  localparam int SETTLE = rlnh_pkg::FINGER_SLOTS_DEF + 2;
  localparam int PHASES = 8;
  localparam int PER_PHASE = 212;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  slot;
    logic [7:0]  node_id;
    logic        slot_valid;
    logic [7:0]  target_id;
    logic [7:0]  hops_in;
    logic [31:0] round_sub;
    logic [31:0] round_cur;
  } route_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  next_hop;
    logic [7:0]  hops_out;
    logic        stop_now;
    logic [31:0] satisfied;
    logic [31:0] hop_sum;
    logic [7:0]  hop_peak;
    logic [47:0] latency;
  } route_result_t;

  typedef struct packed {
    route_item_t item;
    logic        typed;
    logic [1:0]  action;
    logic [7:0]  next_hop;
    logic [7:0]  hops_out;
    logic        stop_now;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_idx = rlnh_pkg::REG_SELF_ID;
  logic [31:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = rlnh_pkg::OP_WRITE;
  logic [3:0] slot = '0;
  logic [7:0] node_id = '0;
  logic slot_valid = 1'b0;
  logic [7:0] target_id = '0;
  logic [7:0] hops_in = '0;
  logic [31:0] round_submitted = '0;
  logic [31:0] current_round = '0;
  logic done;
  logic [1:0] action;
  logic [7:0] next_hop;
  logic [7:0] hops_out;
  logic stop_now;
  logic [31:0] satisfied_count;
  logic [31:0] total_hops;
  logic [7:0] max_hops;
  logic signed [47:0] total_latency;

  ring_lookup_next_hop_router_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_idx         (cfg_idx),
    .cfg_data        (cfg_data),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .slot            (slot),
    .node_id         (node_id),
    .slot_valid      (slot_valid),
    .target_id       (target_id),
    .hops_in         (hops_in),
    .round_submitted (round_submitted),
    .current_round   (current_round),
    .done            (done),
    .action          (action),
    .next_hop        (next_hop),
    .hops_out        (hops_out),
    .stop_now        (stop_now),
    .satisfied_count (satisfied_count),
    .total_hops      (total_hops),
    .max_hops        (max_hops),
    .total_latency   (total_latency)
  );

  always #4 clk = ~clk;

  // Predictor state: finger table, registers and delivery totals.
  logic [7:0]  fingers_id [SLOTS];
  logic        fingers_ok [SLOTS] = '{default: 1'b0};
  logic [7:0]  node_self = '0;
  logic [31:0] stop_level = '0;
  logic [31:0] delivered_cnt = '0;
  logic [31:0] hop_total = '0;
  logic [7:0]  hop_max = '0;
  logic [47:0] latency_acc = '0;
  logic        stop_fired = 1'b0;

  route_result_t pending_results [$];
  script_row_t script [$];
  int mismatches = 0;
  int items_sent = 0;
  int settings_used = 0;
  int action_tally [4] = '{default: 0};
  route_result_t want_res;
  route_result_t seen_res;

  function automatic route_result_t route_predict(input route_item_t it, output bit has_res);
    route_result_t r;
    logic [7:0] tdist;
    logic [7:0] d;
    logic [7:0] best_d;
    logic [7:0] hops;
    logic [32:0] wide_sum;
    bit found;
    int i;
    r = '0;
    has_res = (it.op != OP_UNUSED);
    found = 1'b0;
    best_d = '0;
    hops = (it.op == rlnh_pkg::OP_SUBMIT) ? 8'd0 : it.hops_in;
    if (it.op == rlnh_pkg::OP_WRITE) begin
      fingers_id[it.slot] = it.node_id;
      fingers_ok[it.slot] = it.slot_valid;
      r.action = rlnh_pkg::ACT_WRITTEN;
    end else if (has_res && it.target_id == node_self) begin
      r.action = rlnh_pkg::ACT_DELIVER;
      r.hops_out = hops;
      if (delivered_cnt != 32'hFFFF_FFFF) delivered_cnt = delivered_cnt + 32'd1;
      if (it.op == rlnh_pkg::OP_LOOKUP) begin
        wide_sum = {1'b0, hop_total} + 33'(hops);
        hop_total = wide_sum[32] ? 32'hFFFF_FFFF : wide_sum[31:0];
        if (hops > hop_max) hop_max = hops;
        if (!stop_fired && stop_level != 0 && delivered_cnt >= stop_level) begin
          stop_fired = 1'b1;
          r.stop_now = 1'b1;
        end
        latency_acc = latency_acc + {16'd0, it.round_cur} - {16'd0, it.round_sub};
      end
    end else if (has_res) begin
      tdist = it.target_id - node_self;
      for (i = 0; i < SLOTS; i++) begin
        d = fingers_id[i] - node_self;
        if (fingers_ok[i] && d != 0 && d <= tdist && (!found || d > best_d)) begin
          found = 1'b1;
          best_d = d;
          r.next_hop = fingers_id[i];
        end
      end
      if (!found) begin
        for (i = 0; i < SLOTS; i++) begin
          d = fingers_id[i] - node_self;
          if (fingers_ok[i] && d != 0 && (!found || d < best_d)) begin
            found = 1'b1;
            best_d = d;
            r.next_hop = fingers_id[i];
          end
        end
      end
      if (found) begin
        r.action = rlnh_pkg::ACT_FWD;
        r.hops_out = (hops == 8'd255) ? 8'd255 : hops + 8'd1;
      end else begin
        r.action = rlnh_pkg::ACT_DROP;
        r.hops_out = hops;
      end
    end
    r.satisfied = delivered_cnt;
    r.hop_sum = hop_total;
    r.hop_peak = hop_max;
    r.latency = latency_acc;
    return r;
  endfunction

  function automatic void add_row(input logic [1:0] o, input logic [3:0] s,
                                  input logic [7:0] n, input logic v, input logic [7:0] t,
                                  input logic [7:0] h, input logic [31:0] rs,
                                  input logic [31:0] rc, input logic chk,
                                  input logic [1:0] a, input logic [7:0] nh,
                                  input logic [7:0] ho, input logic sp);
    script_row_t row;
    row.item = '{o, s, n, v, t, h, rs, rc};
    row.typed = chk;
    row.action = a;
    row.next_hop = nh;
    row.hops_out = ho;
    row.stop_now = sp;
    script.insert(script.size(), row);
  endfunction

  task automatic hold_off(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic drain;
    hold_off(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == rlnh_pkg::REG_SELF_ID) node_self = value[7:0];
    else stop_level = value;
  endtask

  // Presents one beat and waits for it to be taken; start is left high.
  task automatic send_item(input route_item_t it, input logic typed, input script_row_t row);
    route_result_t want;
    bit has_res;
    @(negedge clk);
    start <= 1'b1;
    op <= it.op;
    slot <= it.slot;
    node_id <= it.node_id;
    slot_valid <= it.slot_valid;
    target_id <= it.target_id;
    hops_in <= it.hops_in;
    round_submitted <= it.round_sub;
    current_round <= it.round_cur;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = route_predict(it, has_res);
    if (typed) begin
      want.action = row.action;
      want.next_hop = row.next_hop;
      want.hops_out = row.hops_out;
      want.stop_now = row.stop_now;
    end
    if (has_res) pending_results.insert(pending_results.size(), want);
    if (it.op != OP_UNUSED) items_sent++;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      seen_res.action = action;
      seen_res.next_hop = next_hop;
      seen_res.hops_out = hops_out;
      seen_res.stop_now = stop_now;
      seen_res.satisfied = satisfied_count;
      seen_res.hop_sum = total_hops;
      seen_res.hop_peak = max_hops;
      seen_res.latency = total_latency;
      if (pending_results.size() == 0) begin
        $error("unexpected result: action %0d next_hop %0d", action, next_hop);
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        check_field("action", want_res.action, seen_res.action);
        check_field("next_hop", want_res.next_hop, seen_res.next_hop);
        check_field("hops_out", want_res.hops_out, seen_res.hops_out);
        check_field("stop_now", want_res.stop_now, seen_res.stop_now);
        check_field("satisfied_count", want_res.satisfied, seen_res.satisfied);
        check_field("total_hops", want_res.hop_sum, seen_res.hop_sum);
        check_field("max_hops", want_res.hop_peak, seen_res.hop_peak);
        check_field("total_latency", want_res.latency, seen_res.latency);
        action_tally[seen_res.action]++;
      end
    end
  end

  initial begin : stimulus
    route_item_t it;
    script_row_t blank;
    logic [31:0] rnd;
    logic [31:0] thr;
    int ph;
    int k;
    int j;
    int pick;
    bit calm;
    blank = '0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    rnd = $urandom;
    write_reg(rlnh_pkg::REG_SELF_ID, {rnd[31:8], 8'd0});
    write_reg(rlnh_pkg::REG_STOP_THR, 32'd4);
    settings_used++;

    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd0, 8'd255, 32'd0, 32'hFFFF_FFFF, 1,
            rlnh_pkg::ACT_DELIVER, 0, 255, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd5, 8'd7, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_DROP, 0, 7, 0);
    add_row(rlnh_pkg::OP_SUBMIT, 0, 0, 0, 8'd0, 8'd200, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_DELIVER, 0, 0, 0);
    add_row(rlnh_pkg::OP_SUBMIT, 0, 0, 0, 8'd9, 8'd200, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_DROP, 0, 0, 0);
    add_row(OP_UNUSED, 4'd15, 8'd255, 1, 8'd255, 8'd255, '1, '1, 0, 0, 0, 0, 0);
    add_row(rlnh_pkg::OP_WRITE, 4'd0, 8'd0, 1, 8'd0, 8'd0, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_WRITTEN, 0, 0, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd9, 8'd3, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_DROP, 0, 3, 0);
    add_row(rlnh_pkg::OP_WRITE, 4'd15, 8'd255, 1, 8'd0, 8'd0, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_WRITTEN, 0, 0, 0);
    add_row(rlnh_pkg::OP_WRITE, 4'd3, 8'd16, 1, 8'd0, 8'd0, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_WRITTEN, 0, 0, 0);
    add_row(rlnh_pkg::OP_WRITE, 4'd4, 8'd16, 1, 8'd0, 8'd0, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_WRITTEN, 0, 0, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd20, 8'd254, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_FWD, 16, 255, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd10, 8'd255, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_FWD, 16, 255, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd255, 8'd0, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_FWD, 255, 1, 0);
    add_row(rlnh_pkg::OP_WRITE, 4'd4, 8'd128, 0, 8'd0, 8'd0, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_WRITTEN, 0, 0, 0);
    add_row(rlnh_pkg::OP_WRITE, 4'd9, 8'd200, 1, 8'd0, 8'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd199, 8'd9, 32'd0, 32'd0, 0, 0, 0, 0, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd0, 8'd100, 32'd10, 32'd3, 0, 0, 0, 0, 0);
    add_row(rlnh_pkg::OP_SUBMIT, 0, 0, 0, 8'd0, 8'd0, 32'd0, 32'd0, 1,
            rlnh_pkg::ACT_DELIVER, 0, 0, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd0, 8'd1, 32'd5, 32'd9, 1,
            rlnh_pkg::ACT_DELIVER, 0, 1, 1);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd0, 8'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0);
    add_row(rlnh_pkg::OP_WRITE, 4'd15, 8'd255, 0, 8'd0, 8'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd254, 8'd50, 32'd0, 32'd0, 0, 0, 0, 0, 0);
    add_row(rlnh_pkg::OP_LOOKUP, 0, 0, 0, 8'd128, 8'd2, 32'hFFFF_FFFF, 32'd0,
            0, 0, 0, 0, 0);

    foreach (script[i]) send_item(script[i].item, script[i].typed, script[i]);

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      rnd = $urandom;
      case (ph)
        0: rnd[7:0] = 8'd255;
        1: rnd[7:0] = 8'd0;
        default: ;
      endcase
      write_reg(rlnh_pkg::REG_SELF_ID, rnd);
      case (ph)
        0: thr = 32'hFFFF_FFFF;
        1: thr = 32'd0;
        2: thr = 32'd1;
        default: thr = $urandom;
      endcase
      write_reg(rlnh_pkg::REG_STOP_THR, thr);
      settings_used++;
      k = 0;
      while (k < PER_PHASE) begin
        if (k % 40 == 0) calm = ($urandom_range(0, 2) == 0);
        if (!calm && ph != PHASES - 1 && $urandom_range(0, 3) == 0)
          hold_off($urandom_range(1, 19));
        it.slot = 4'($urandom);
        it.node_id = 8'($urandom);
        it.slot_valid = ($urandom_range(0, 3) != 0);
        it.target_id = 8'($urandom);
        it.hops_in = 8'($urandom);
        it.round_sub = $urandom;
        it.round_cur = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 25) it.op = rlnh_pkg::OP_WRITE;
        else if (pick < 70) it.op = rlnh_pkg::OP_LOOKUP;
        else if (pick < 95) it.op = rlnh_pkg::OP_SUBMIT;
        else it.op = OP_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          it.target_id = node_self;
        end else if (pick < 60) begin
          j = $urandom_range(0, SLOTS - 1);
          if (fingers_ok[j]) it.target_id = 8'(fingers_id[j] + $urandom_range(0, 4) - 2);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) it.hops_in = 8'd255;
        else if (pick == 1) it.hops_in = 8'd254;
        send_item(it, 1'b0, blank);
        if (it.op != OP_UNUSED) k++;
      end
    end

    drain();
    $display("Covered %0d items over %0d register settings.", items_sent, settings_used);
    $display("Results seen: %0d forwarded, %0d delivered, %0d dropped, %0d slot writes.",
             action_tally[rlnh_pkg::ACT_FWD], action_tally[rlnh_pkg::ACT_DELIVER],
             action_tally[rlnh_pkg::ACT_DROP], action_tally[rlnh_pkg::ACT_WRITTEN]);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
